FILE: rtl/spq_pkg.sv
// Shared types, widths and codes for the stable minimum priority queue.
// Used by the queue top level, its entry RAM wiring and the port checker.
package spq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int PRIORITY_BITS = 8;

    localparam int DATA_W    = 32;
    localparam int PRIO_IN_W = 8;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 7;

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = DATA_W + PRIORITY_BITS;

    localparam int IN_TDATA_W  = ((DATA_W + PRIO_IN_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = DATA_W + PRIO_IN_W + FILL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef logic [STATUS_W-1:0] status_t;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

FILE: rtl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/stable_min_priority_queue.sv
// Stable minimum priority queue: entries held in insertion order in one RAM.
// An enqueue or an empty dequeue passes through S_RESULT to the output register, which raises
// m_axis_tvalid. A dequeue first scans all N entries for the oldest minimum at position k, then
// moves the entries behind k down by one: one RAM read per cycle for the scan,
// then one read and one write per cycle to close the gap. One request is in work at a time;
// s_axis_tready rises with m_axis_tvalid, so the next word can be taken while the result stalls.
module stable_min_priority_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, low bit up: item_data[31:0], item_priority[39:32].
    input  logic [spq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type (0 enqueue, 1 dequeue).
    input  logic                           s_axis_tuser,
    // Result channel.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, low bit up: out_data[31:0], out_priority[39:32], fill_level[46:40],
    // then zero padding.
    output logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status (0 done, 1 full, 2 empty).
    output logic [spq_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import spq_pkg::*;

    // Controller states.
    localparam logic [1:0] S_IDLE   = 2'd0;  // waiting for a request word
    localparam logic [1:0] S_SCAN   = 2'd1;  // reading every entry to find the minimum
    localparam logic [1:0] S_SHIFT  = 2'd2;  // moving later entries down by one
    localparam logic [1:0] S_RESULT = 2'd3;  // handing the result to the output register

    logic [1:0]               state_reg;
    logic [CNT_W-1:0]         count_reg;

    // Read sequencing: issue_reg is the next address to read; rvalid_reg and
    // ridx_reg track the word arriving from the RAM this cycle.
    logic [CNT_W-1:0]         issue_reg;
    logic                     rvalid_reg;
    logic [CNT_W-1:0]         ridx_reg;

    // Running minimum of the scan.
    logic [CNT_W-1:0]         best_idx_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic [DATA_W-1:0]        best_data_reg;

    // Finished result waiting for the output register.
    logic [DATA_W-1:0]        res_data_reg;
    logic [PRIORITY_BITS-1:0] res_prio_reg;
    status_t                  res_status_reg;

    // Output register.
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        out_data_reg;
    logic [PRIO_IN_W-1:0]     out_prio_reg;
    logic [FILL_W-1:0]        out_fill_reg;
    status_t                  out_status_reg;

    // RAM ports.
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;

    logic                     s_accept;
    logic                     req_type;
    logic [DATA_W-1:0]        in_data;
    logic [PRIORITY_BITS-1:0] in_prio;
    logic                     not_full;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [DATA_W-1:0]        rd_data;
    logic                     take;
    logic [CNT_W-1:0]         best_idx_next;
    logic [CNT_W-1:0]         last_idx;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign req_type = s_axis_tuser;
    assign in_data  = s_axis_tdata[DATA_W-1:0];
    // The stored priority keeps only PRIORITY_BITS bits of the request field.
    assign in_prio  = PRIORITY_BITS'(s_axis_tdata[DATA_W +: PRIO_IN_W]);

    assign not_full = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign last_idx = count_reg - CNT_W'(1);

    assign rd_prio = ram_rdata[DATA_W +: PRIORITY_BITS];
    assign rd_data = ram_rdata[DATA_W-1:0];

    // Strictly smaller wins, so among equal priorities the oldest entry stays chosen.
    assign take = rvalid_reg && ((ridx_reg == '0) || (rd_prio < best_prio_reg));
    assign best_idx_next = take ? ridx_reg : best_idx_reg;

    // Entry store: priority above data in each word.
    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM access. An enqueue writes straight at the tail. During the compaction
    // pass entry i+1 is read while the word read last cycle, entry i, goes to
    // entry i-1, so the write always trails the read and never collides.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && (req_type == REQ_ENQ) && not_full) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(count_reg);
                    ram_wdata = {in_prio, in_data};
                end
            end
            S_SCAN: begin
                if (issue_reg < count_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(issue_reg);
                end
            end
            S_SHIFT: begin
                if (issue_reg < count_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(issue_reg);
                end
                if (rvalid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(ridx_reg - CNT_W'(1));
                    ram_wdata = ram_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        ridx_reg <= issue_reg;
        if (take) begin
            best_idx_reg  <= ridx_reg;
            best_prio_reg <= rd_prio;
            best_data_reg <= rd_data;
        end
    end

    // Control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rvalid_reg <= ram_re;
            // In S_RESULT the output register is reloaded below instead.
            if (m_valid_reg && m_axis_tready && (state_reg != S_RESULT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        res_data_reg <= '0;
                        res_prio_reg <= '0;
                        if (req_type == REQ_ENQ) begin
                            if (not_full) begin
                                count_reg      <= count_reg + CNT_W'(1);
                                res_status_reg <= ST_DONE;
                            end else begin
                                res_status_reg <= ST_FULL;
                            end
                            state_reg <= S_RESULT;
                        end else if (count_reg == '0) begin
                            res_status_reg <= ST_EMPTY;
                            state_reg      <= S_RESULT;
                        end else begin
                            issue_reg <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (ram_re) begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                    // Last entry compared: start moving the entries behind the winner.
                    if (rvalid_reg && (ridx_reg == last_idx)) begin
                        issue_reg <= best_idx_next + CNT_W'(1);
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (ram_re) begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                    if (!ram_re && !rvalid_reg) begin
                        count_reg      <= last_idx;
                        res_data_reg   <= best_data_reg;
                        res_prio_reg   <= best_prio_reg;
                        res_status_reg <= ST_DONE;
                        state_reg      <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg    <= 1'b1;
                        out_data_reg   <= res_data_reg;
                        out_prio_reg   <= PRIO_IN_W'(res_prio_reg);
                        out_fill_reg   <= FILL_W'(count_reg);
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_fill_reg, out_prio_reg, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

FILE: rtl/spq_checker.sv
// Port-level checker for the stable minimum priority queue, bound to its top level.
// Depends on spq_pkg for widths and status codes.
module spq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [spq_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import spq_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Only one request is in work: no request word right after one is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // A dropped enqueue reports a full queue and no item.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
            (m_axis_tdata[DATA_W+PRIO_IN_W +: FILL_W] == FILL_W'(QUEUE_DEPTH)) &&
            (m_axis_tdata[DATA_W+PRIO_IN_W-1:0] == '0))
        else $error("full status with wrong fill level or nonzero item");

    // An empty dequeue reports an empty queue and no item.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
            (m_axis_tdata[DATA_W+PRIO_IN_W +: FILL_W] == '0) &&
            (m_axis_tdata[DATA_W+PRIO_IN_W-1:0] == '0))
        else $error("empty status with nonzero fill level or item");

endmodule

bind stable_min_priority_queue spq_checker u_spq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
